// ===== hdl/rtq_pkg.sv =====
// shared types, codes and reset values for the retransmit queue
// no dependencies; imported by rtq_ctrl, rtq_datapath and the top level
package rtq_pkg;

  localparam int QUEUE_DEPTH_DEFAULT  = 16;
  localparam int HANDLE_SLOTS_DEFAULT = 256;

  localparam logic [15:0] SILENCE_GAP_RESET = 16'd100;
  localparam logic [15:0] RETRY_GAP_RESET   = 16'd500;
  localparam logic [7:0]  MIN_RETRY_RESET   = 8'd1;
  localparam logic [15:0] DEADLINE_RESET    = 16'd4000;
  localparam logic [7:0]  RETRY_MAX         = 8'd255;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_ENQ  = 2'd1,
    ACT_ACK  = 2'd2,
    ACT_RX   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    EV_SEND   = 2'd0,
    EV_DROP   = 2'd1,
    EV_REJECT = 2'd2
  } event_t;

  typedef enum logic [1:0] {
    CFG_SILENCE_GAP = 2'd0,
    CFG_RETRY_GAP   = 2'd1,
    CFG_MIN_RETRY   = 2'd2,
    CFG_DEADLINE    = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic accept;
    logic eval;
    logic load_out;
  } rtq_cmd_t;

  typedef struct packed {
    logic need_eval;
    logic result_now;
    logic eval_result;
  } rtq_status_t;

endpackage

// ===== hdl/retransmit_queue_with_ack_timeout.sv =====
// top level of the retransmit queue with acknowledge timeout
// depends on rtq_pkg, rtq_ctrl, rtq_datapath (and rtq_ram below it)
//
// usage:
//   s_* carries commands: tuser is the action (tick, enqueue, acknowledge,
//   receive frame consumed), tdata the packet id, payload handle and the
//   receive-pending flag. m_* carries events: tuser is the kind (send, drop,
//   reject), tdata the id, handle and retry count.
//   cfg_* writes the silence gap, retry gap, minimum retry count and packet
//   lifetime by index; it is always ready. the user must see that it is
//   written only while idle; the block does not enforce it. an item that
//   inspects the queue head (a tick with no receive pending or an acknowledge,
//   with the queue not empty) passes through a head-check state because the
//   head entry comes from the entry ram through its registered read port;
//   every other item skips that state. an item with an event then goes to a
//   result state that moves the event into the output register.
//   reset clears time, pointers and fill count and loads config defaults;
//   the entry ram is not cleared. when the receiver stalls, the event waits
//   in the output register; the next item is still taken, and one that
//   produces another event waits until the output register is free.
module retransmit_queue_with_ack_timeout #(
  parameter int QUEUE_DEPTH  = rtq_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int HANDLE_SLOTS = rtq_pkg::HANDLE_SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // packet_id, payload_handle, rx_pending, zero pad
  input  logic [1:0]  s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // out_packet_id, out_payload_handle, retry_total
  output logic [1:0]  m_tuser,   // event_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import rtq_pkg::*;

  rtq_cmd_t    cmd;
  rtq_status_t st;

  rtq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .st       (st),
    .cmd      (cmd)
  );

  rtq_datapath #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .HANDLE_SLOTS (HANDLE_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

// ===== hdl/rtq_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module rtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/rtq_datapath.sv =====
// datapath: config registers, clocks, queue pointers, entry ram and head checks
// depends on rtq_pkg and rtq_ram
module rtq_datapath #(
  parameter int QUEUE_DEPTH  = rtq_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int HANDLE_SLOTS = rtq_pkg::HANDLE_SLOTS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [23:0]          s_tdata,
  input  logic [1:0]           s_tuser,
  output logic [23:0]          m_tdata,
  output logic [1:0]           m_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  rtq_pkg::rtq_cmd_t    cmd,
  output rtq_pkg::rtq_status_t st
);
  import rtq_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int HW = (HANDLE_SLOTS > 1) ? $clog2(HANDLE_SLOTS) : 1;
  localparam int HND_LSB  = 8;
  localparam int DL_LSB   = HND_LSB + HW;
  localparam int NR_LSB   = DL_LSB + 32;
  localparam int RT_LSB   = NR_LSB + 32;
  localparam int SENT_BIT = RT_LSB + 8;
  localparam int EW       = SENT_BIT + 1;
  localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  logic [15:0]   silence_gap;
  logic [15:0]   retry_gap;
  logic [7:0]    min_retry;
  logic [15:0]   lifetime;
  logic [31:0]   now_ms;
  logic [31:0]   last_activity;
  logic [PW-1:0] head_ptr;
  logic [PW-1:0] tail_ptr;
  logic [CW-1:0] fill_count;

  action_t       item_action;
  logic [7:0]    item_id;

  event_t        res_kind;
  logic [7:0]    res_id;
  logic [7:0]    res_handle;
  logic [7:0]    res_retries;

  event_t        out_kind;
  logic [7:0]    out_id;
  logic [7:0]    out_handle;
  logic [7:0]    out_retries;

  logic [HW-1:0] handle_lut [256];
  action_t       in_action;
  logic [7:0]    in_id;
  logic [HW-1:0] in_handle;
  logic          in_rx;
  logic          full;
  logic          empty;
  logic          enq_store;

  logic          we;
  logic [PW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic [EW-1:0] rd_data;

  logic [7:0]    hd_id;
  logic [HW-1:0] hd_handle;
  logic [31:0]   hd_deadline;
  logic [31:0]   hd_next_retry;
  logic [7:0]    hd_retries;
  logic          hd_sent;
  logic [31:0]   since_deadline;
  logic [31:0]   since_retry;
  logic [31:0]   since_activity;
  logic          expired;
  logic          retry_due;
  logic          quiet;
  logic          drop;
  logic          send;
  logic          ack_hit;
  logic [7:0]    new_retries;
  logic [31:0]   new_next_retry;

  // handle reduced by the slot count, as a constant table
  for (genvar v = 0; v < 256; v++) begin : g_handle_lut
    assign handle_lut[v] = HW'(v % HANDLE_SLOTS);
  end

  // input decode, tdata: packet_id, payload_handle, rx_pending
  assign in_action = action_t'(s_tuser);
  assign in_id     = s_tdata[7:0];
  assign in_handle = handle_lut[s_tdata[15:8]];
  assign in_rx     = s_tdata[16];
  assign full      = (fill_count == FULL_CNT);
  assign empty     = (fill_count == '0);
  assign enq_store = (in_action == ACT_ENQ) && (in_id != 8'd0) && !full;

  // head entry fields
  assign hd_id         = rd_data[7:0];
  assign hd_handle     = rd_data[HND_LSB +: HW];
  assign hd_deadline   = rd_data[DL_LSB +: 32];
  assign hd_next_retry = rd_data[NR_LSB +: 32];
  assign hd_retries    = rd_data[RT_LSB +: 8];
  assign hd_sent       = rd_data[SENT_BIT];

  // modular time checks on the head
  assign since_deadline = now_ms - hd_deadline;
  assign since_retry    = now_ms - hd_next_retry;
  assign since_activity = now_ms - last_activity;
  assign expired        = !since_deadline[31];
  assign retry_due      = !hd_sent || ((since_retry != 32'd0) && !since_retry[31]);
  assign quiet          = since_activity > {16'd0, silence_gap};
  assign drop           = (item_action == ACT_TICK) && expired && (hd_retries >= min_retry);
  assign send           = (item_action == ACT_TICK) && !drop && quiet && retry_due;
  assign ack_hit        = (item_action == ACT_ACK) && (hd_id == item_id);
  assign new_retries    = (hd_sent && hd_retries != RETRY_MAX) ? hd_retries + 8'd1 : hd_retries;
  assign new_next_retry = now_ms + {16'd0, retry_gap};

  assign st.need_eval   = !empty &&
                          (((in_action == ACT_TICK) && !in_rx) || (in_action == ACT_ACK));
  assign st.result_now  = (in_action == ACT_ENQ) && ((in_id == 8'd0) || full);
  assign st.eval_result = drop || send;

  // ram write port: enqueue at tail, send updates the head
  assign we      = (cmd.accept && enq_store) || (cmd.eval && send);
  assign wr_addr = cmd.accept ? tail_ptr : head_ptr;
  always_comb begin
    if (cmd.accept) begin
      wr_data = {1'b0, 8'd0, 32'd0, now_ms + {16'd0, lifetime}, in_handle, in_id};
    end else begin
      wr_data = {1'b1, new_retries, new_next_retry, hd_deadline, hd_handle, hd_id};
    end
  end

  rtq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (head_ptr),
    .rd_data (rd_data)
  );

  // config registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      silence_gap <= SILENCE_GAP_RESET;
      retry_gap   <= RETRY_GAP_RESET;
      min_retry   <= MIN_RETRY_RESET;
      lifetime    <= DEADLINE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SILENCE_GAP: silence_gap <= cfg_data;
        CFG_RETRY_GAP:   retry_gap   <= cfg_data;
        CFG_MIN_RETRY:   min_retry   <= cfg_data[7:0];
        CFG_DEADLINE:    lifetime    <= cfg_data;
        default: ;
      endcase
    end
  end

  // clocks, pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms        <= '0;
      last_activity <= '0;
      head_ptr      <= '0;
      tail_ptr      <= '0;
      fill_count    <= '0;
    end else if (cmd.accept) begin
      if (in_action == ACT_TICK) begin
        now_ms <= now_ms + 32'd1;
      end
      if ((in_action == ACT_RX) || ((in_action == ACT_ENQ) && (in_id == 8'd0))) begin
        last_activity <= now_ms;
      end
      if (enq_store) begin
        tail_ptr   <= (tail_ptr == LAST_PTR) ? '0 : tail_ptr + 1'b1;
        fill_count <= fill_count + 1'b1;
      end
    end else if (cmd.eval) begin
      if (send) begin
        last_activity <= now_ms;
      end
      if (drop || ack_hit) begin
        head_ptr   <= (head_ptr == LAST_PTR) ? '0 : head_ptr + 1'b1;
        fill_count <= fill_count - 1'b1;
      end
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_action <= in_action;
      item_id     <= in_id;
      res_kind    <= (in_id == 8'd0) ? EV_SEND : EV_REJECT;
      res_id      <= in_id;
      res_handle  <= 8'(in_handle);
      res_retries <= 8'd0;
    end else if (cmd.eval) begin
      res_kind    <= drop ? EV_DROP : EV_SEND;
      res_id      <= hd_id;
      res_handle  <= 8'(hd_handle);
      res_retries <= drop ? hd_retries : new_retries;
    end
    if (cmd.load_out) begin
      out_kind    <= res_kind;
      out_id      <= res_id;
      out_handle  <= res_handle;
      out_retries <= res_retries;
    end
  end

  assign m_tuser = out_kind;
  assign m_tdata = {out_retries, out_handle, out_id};

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FULL_CNT)
    else $error("fill count beyond queue depth");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    fill_count == $past(fill_count) || fill_count == $past(fill_count) + 1'b1 ||
    fill_count + 1'b1 == $past(fill_count))
    else $error("fill count moved by more than one");

  a_tick_time: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && in_action == ACT_TICK |=> now_ms == $past(now_ms) + 32'd1)
    else $error("tick did not advance time");

endmodule

// ===== hdl/rtq_ctrl.sv =====
// controller: sequences accept, head check and result transfer
// depends on rtq_pkg
module rtq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  rtq_pkg::rtq_status_t st,
  output rtq_pkg::rtq_cmd_t    cmd
);
  import rtq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EVAL = 3'b010,
    ST_PUSH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready     = (state == ST_IDLE);
  assign cmd.accept   = s_tready && s_tvalid;
  assign cmd.eval     = (state == ST_EVAL);
  assign cmd.load_out = (state == ST_PUSH) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.accept) begin
          if (st.need_eval) begin
            state_next = ST_EVAL;
          end else if (st.result_now) begin
            state_next = ST_PUSH;
          end
        end
      end
      ST_EVAL: begin
        state_next = st.eval_result ? ST_PUSH : ST_IDLE;
      end
      ST_PUSH: begin
        if (cmd.load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_eval_after_accept: assert property (@(posedge clk) disable iff (rst)
    state == ST_EVAL |-> $past(cmd.accept))
    else $error("head check without an accepted item");

  a_result_from_push: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_PUSH))
    else $error("result appeared outside the result stage");

  a_immediate_result: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && !st.need_eval && st.result_now |=> state == ST_PUSH)
    else $error("immediate result not staged");

endmodule
